[design/vortex_flow_particle_advect_defines.svh]
// Assertion macros shared by the checker.
`ifndef VORTEX_FLOW_PARTICLE_ADVECT_DEFINES_SVH
`define VORTEX_FLOW_PARTICLE_ADVECT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define VFPA_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Signal holds over the next edge whenever the condition is seen.
`define VFPA_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

[design/vfpa_pkg.sv]
package vfpa_pkg;

    localparam int POSITION_BITS_DEF    = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam int PHASE_BITS = 17;
    localparam int STEP_BITS  = 16;
    localparam int CFG_DATA_BITS = 17;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TIME_PHASE = 1'b0;
    localparam t_cfg_idx CFG_STEP_SIZE  = 1'b1;

    localparam logic [PHASE_BITS-1:0] TIME_PHASE_RST = 17'd0;
    localparam logic [STEP_BITS-1:0]  STEP_SIZE_RST  = 16'd655;

    // Trig values: signed Q1.15, -32768..32768
    typedef logic signed [16:0] t_trig;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned COEF1 = 64'd1686629713;
    localparam longint unsigned COEF3 = 64'd693598669;
    localparam longint unsigned COEF5 = 64'd85569306;
    localparam longint unsigned COEF7 = 64'd5026995;
    localparam longint unsigned COEF9 = 64'd172272;

    // Full-turn sine table entry k of a 2^lg entry table.
    function automatic t_trig sine_entry(input int unsigned k, input int lg);
        longint unsigned q, r, z, z2, acc, s, v;
        t_trig res;
        q   = (64'(k) << 2) >> lg;
        r   = (64'(k) << 2) - (q << lg);
        z   = r << (30 - lg);
        if (q[0]) begin
            z = Q30_ONE - z;
        end
        z2  = (z * z) >> 30;
        acc = COEF9;
        acc = COEF7 - ((acc * z2) >> 30);
        acc = COEF5 - ((acc * z2) >> 30);
        acc = COEF3 - ((acc * z2) >> 30);
        acc = COEF1 - ((acc * z2) >> 30);
        s   = (acc * z) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        v   = (s + 64'd16384) >> 15;
        res = t_trig'(v);
        if (q[1]) begin
            res = -res;
        end
        return res;
    endfunction

endpackage

[design/vfpa_sine_rom.sv]
module vfpa_sine_rom #(
    parameter int SINE_TABLE_DEPTH = vfpa_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_addr_a,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_addr_b,
    output vfpa_pkg::t_trig                     o_data_a,
    output vfpa_pkg::t_trig                     o_data_b
);
    import vfpa_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH);

    t_trig w_rom [SINE_TABLE_DEPTH];
    t_trig r_data_a, r_data_b;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = sine_entry(g, AW);
    end

    // Registered dual read; hold while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= w_rom[i_addr_a];
            r_data_b <= w_rom[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

[design/vortex_flow_particle_advect.sv]
// Single-vortex deformation flow, one explicit Euler step per particle.
// Each transaction carries one position (x, y) in unsigned Q0.P; the result
// transaction carries x + dt*u and y + dt*v, saturated to 0..2^P-1, where
// u = -2 cos(pi t/T) sin^2(pi x) cos(pi y) sin(pi y) and v is its mirror.
// Sines and cosines come from full-turn sine tables (power-of-two depth):
// one table per axis reads sin and cos in the same cycle, a third reads the
// time cosine from the time_phase register. The pipeline is seven register
// stages deep: table read, four Q15 products per velocity component, the
// step-size product with rounding, and the saturating add into the output
// register. One transaction enters per cycle while o_stall is low. The
// whole pipeline advances together and holds only while a result waits
// in the output register and i_stall is high, so o_stall follows i_stall
// combinationally in that case. Configuration (register 0 time_phase, 17
// bits; register 1 step_size, 16 bits) is always ready and must be written
// only while the pipeline is empty.
module vortex_flow_particle_advect #(
    parameter int POSITION_BITS    = vfpa_pkg::POSITION_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = vfpa_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [POSITION_BITS-1:0]           i_x_position,
    input  logic [POSITION_BITS-1:0]           i_y_position,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [POSITION_BITS-1:0]           o_new_x_position,
    output logic [POSITION_BITS-1:0]           o_new_y_position,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  vfpa_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [vfpa_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import vfpa_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int NW = P + 1 + AW;           // angle numerator scaled by depth
    localparam int TW = PHASE_BITS + 1 + AW;
    localparam int DW = P + 36;               // displacement and sum width
    localparam int SH = (P < 30) ? (30 - P) : 1;
    localparam int LS = (P > 30) ? (P - 30) : 0;
    localparam int NSTG = 7;

    // Q15 product, rounded half away from zero
    function automatic t_trig mul_q15(input t_trig a, input t_trig b);
        logic signed [33:0] p;
        logic [33:0] m;
        logic [33:0] r;
        p = a * b;
        m = p[33] ? 34'(-p) : 34'(p);
        r = (m + 34'd16384) >> 15;
        return p[33] ? t_trig'(-r) : t_trig'(r);
    endfunction

    // dt * 2w scaled to position units
    function automatic logic signed [DW-1:0] disp(input logic [STEP_BITS-1:0] dt,
                                                   input t_trig w);
        logic signed [34:0] p;
        logic [34:0] m;
        logic [34:0] r;
        logic signed [DW-1:0] res;
        p = $signed({1'b0, dt}) * w;
        m = p[34] ? 35'(-p) : 35'(p);
        r = (m + (35'd1 << (SH - 1))) >> SH;
        if (P < 30) begin
            res = p[34] ? -DW'(r) : DW'(r);
        end else begin
            res = DW'(p) <<< LS;
        end
        return res;
    endfunction

    // Table index of an angle num / 2^(P+1) turn
    function automatic logic [AW-1:0] x_index(input logic [P:0] num);
        logic [NW-1:0] ext;
        ext = {num, {AW{1'b0}}} >> (P + 1);
        return ext[AW-1:0];
    endfunction

    function automatic logic [P-1:0] sat(input logic signed [DW:0] v);
        logic [P-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed((DW+1)'({P{1'b1}}))) begin
            res = {P{1'b1}};
        end else begin
            res = v[P-1:0];
        end
        return res;
    endfunction

    logic                   en;
    logic [PHASE_BITS-1:0]  r_time_phase;
    logic [STEP_BITS-1:0]   r_step_size;
    logic [NSTG-1:0]        r_vld;

    logic [AW-1:0] w_kxs, w_kxc, w_kys, w_kyc, w_kt;
    logic [TW-1:0] w_text;
    t_trig w_sx, w_cx, w_sy, w_cy, w_ct, w_ct_unused;

    // Positions and trig values carried down the pipe (stage 1..6)
    logic [P-1:0] r_x [1:6];
    logic [P-1:0] r_y [1:6];
    t_trig r_sx [2:4];
    t_trig r_cx [2:3];
    t_trig r_sy [2:4];
    t_trig r_cy [2:3];
    t_trig r_wu [2:5];
    t_trig r_wv [2:5];
    logic signed [DW-1:0] r_du, r_dv;
    logic [P-1:0] r_nx, r_ny;

    // Advance everything unless the finished result is held downstream
    assign en          = !(r_vld[NSTG-1] && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_phase <= TIME_PHASE_RST;
            r_step_size  <= STEP_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_PHASE: r_time_phase <= i_cfg_data[PHASE_BITS-1:0];
                CFG_STEP_SIZE:  r_step_size  <= i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Stage 0: angle indices; cosine adds a quarter turn
    assign w_kxs  = x_index({1'b0, i_x_position});
    assign w_kxc  = x_index({1'b0, i_x_position} + ((P+1)'(1) << (P - 1)));
    assign w_kys  = x_index({1'b0, i_y_position});
    assign w_kyc  = x_index({1'b0, i_y_position} + ((P+1)'(1) << (P - 1)));
    assign w_text = {({1'b0, r_time_phase} + 18'd32768), {AW{1'b0}}} >> PHASE_BITS;
    assign w_kt   = w_text[AW-1:0];

    vfpa_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (w_kxs),
        .i_addr_b (w_kxc),
        .o_data_a (w_sx),
        .o_data_b (w_cx)
    );

    vfpa_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (w_kys),
        .i_addr_b (w_kyc),
        .o_data_a (w_sy),
        .o_data_b (w_cy)
    );

    vfpa_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_t (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (w_kt),
        .i_addr_b (w_kt),
        .o_data_a (w_ct),
        .o_data_b (w_ct_unused)
    );

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1: table outputs land; positions follow
            r_x[1]  <= i_x_position;
            r_y[1]  <= i_y_position;
            // Stage 2: ct * sin
            r_wu[2] <= mul_q15(w_ct, w_sx);
            r_wv[2] <= mul_q15(w_ct, w_sy);
            r_sx[2] <= w_sx;
            r_cx[2] <= w_cx;
            r_sy[2] <= w_sy;
            r_cy[2] <= w_cy;
            // Stage 3: square the sine
            r_wu[3] <= mul_q15(r_wu[2], r_sx[2]);
            r_wv[3] <= mul_q15(r_wv[2], r_sy[2]);
            r_sx[3] <= r_sx[2];
            r_cx[3] <= r_cx[2];
            r_sy[3] <= r_sy[2];
            r_cy[3] <= r_cy[2];
            // Stage 4: cross-axis cosine
            r_wu[4] <= mul_q15(r_wu[3], r_cy[3]);
            r_wv[4] <= mul_q15(r_wv[3], r_cx[3]);
            r_sx[4] <= r_sx[3];
            r_sy[4] <= r_sy[3];
            // Stage 5: cross-axis sine
            r_wu[5] <= mul_q15(r_wu[4], r_sy[4]);
            r_wv[5] <= mul_q15(r_wv[4], r_sx[4]);
            // Stage 6: scale by step size
            r_du    <= disp(r_step_size, r_wu[5]);
            r_dv    <= disp(r_step_size, r_wv[5]);
            // Stage 7: saturating update into the output register
            r_nx    <= sat($signed({{(DW+1-P){1'b0}}, r_x[6]}) - (DW+1)'(r_du));
            r_ny    <= sat($signed({{(DW+1-P){1'b0}}, r_y[6]}) + (DW+1)'(r_dv));
            for (int s = 2; s <= 6; s++) begin
                r_x[s] <= r_x[s-1];
                r_y[s] <= r_y[s-1];
            end
        end
    end

    assign o_valid          = r_vld[NSTG-1];
    assign o_new_x_position = r_nx;
    assign o_new_y_position = r_ny;

endmodule

[design/vfpa_checker.sv]
`include "vortex_flow_particle_advect_defines.svh"

module vfpa_checker #(
    parameter int POSITION_BITS = vfpa_pkg::POSITION_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [POSITION_BITS-1:0]           i_x_position,
    input logic [POSITION_BITS-1:0]           i_y_position,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [POSITION_BITS-1:0]           o_new_x_position,
    input logic [POSITION_BITS-1:0]           o_new_y_position,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input vfpa_pkg::t_cfg_idx                 i_cfg_index,
    input logic [vfpa_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    // Input side stalls only when a finished result is held downstream
    `VFPA_ASSERT_CLK(a_stall_cause, o_stall |-> (o_valid && i_stall), "stall without held result")

    // A held result's x position stays put
    `VFPA_ASSERT_HOLD(a_out_hold, o_valid && i_stall, o_new_x_position, "x changed while held")

    // A held result stays valid
    `VFPA_ASSERT_CLK(a_valid_hold, (o_valid && i_stall) |=> o_valid, "held result dropped")

    // Configuration is never refused
    `VFPA_ASSERT_CLK(a_cfg_ready, o_cfg_ready, "config not ready")

endmodule

bind vortex_flow_particle_advect vfpa_checker #(.POSITION_BITS(POSITION_BITS)) u_vfpa_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the single-vortex particle advection pipeline.
// Drive positions through the valid/stall input channel while the result side
// stalls at random, predict each step in the testbench, and compare the
// returned positions in order. Reprogram time_phase and step_size between
// phases, only after the pipeline has drained.
module tb_top;
    import vfpa_pkg::*;

    localparam int PB          = 16;
    localparam int PIPE_DEPTH  = 7;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 5;
    localparam int STUCK_LIMIT = 5000;

    typedef struct packed {
        logic [PB-1:0] nx;
        logic [PB-1:0] ny;
    } t_pos;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [PB-1:0]            i_x_position;
    logic [PB-1:0]            i_y_position;
    logic                     o_valid;
    logic                     i_stall;
    logic [PB-1:0]            o_new_x_position;
    logic [PB-1:0]            o_new_y_position;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    t_cfg_idx                 i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    vortex_flow_particle_advect DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_x_position     (i_x_position),
        .i_y_position     (i_y_position),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_new_x_position (o_new_x_position),
        .o_new_y_position (o_new_y_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Local copy of the two registers, updated on each accepted write.
    logic [PHASE_BITS-1:0] phase_reg;
    logic [STEP_BITS-1:0]  dt_reg;

    t_pos expected_positions[$];
    int   error_count;
    int   sent_count;
    int   result_count;
    int   cfg_count;
    bit   no_gaps;     // suppress idling on both sides
    int   stuck_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sine table entry k of a 1024-entry full-turn table, signed Q1.15.
    // Quadrant folding plus an odd polynomial evaluated in Q30.
    function automatic longint sine_rom(int unsigned k);
        longint unsigned quad, rem, z, z2, acc, s, mag;
        quad = (4 * longint'(k)) / 1024;
        rem  = 4 * longint'(k) - quad * 1024;
        z    = (rem << 30) / 1024;
        if (quad[0]) begin
            z = (64'd1 << 30) - z;
        end
        z2  = (z * z) >> 30;
        acc = 64'd172272;
        acc = 64'd5026995    - ((acc * z2) >> 30);
        acc = 64'd85569306   - ((acc * z2) >> 30);
        acc = 64'd693598669  - ((acc * z2) >> 30);
        acc = 64'd1686629713 - ((acc * z2) >> 30);
        s   = (acc * z) >> 30;
        if (s > (64'd1 << 30)) begin
            s = 64'd1 << 30;
        end
        mag = (s + 64'd16384) >> 15;
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // Angle of num / 2^bits turn; a cosine adds a quarter turn first.
    function automatic longint turn_trig(longint unsigned num, int bits, bit cosine);
        longint unsigned idx;
        if (cosine) begin
            num = num + (64'd1 << (bits - 2));
        end
        idx = ((num * 1024) >> bits) % 1024;
        return sine_rom(int'(idx));
    endfunction

    // Divide by 2^sh rounding half away from zero.
    function automatic longint round_away(longint p, int sh);
        longint unsigned mag;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v < 0) return 0;
        if (v > (1 << PB) - 1) return (1 << PB) - 1;
        return v;
    endfunction

    // One Euler step through the vortex field at the current register values.
    function automatic t_pos advect_step(logic [PB-1:0] x, logic [PB-1:0] y);
        longint sx, cx, sy, cy, ct, wu, wv, du, dv;
        t_pos r;
        sx = turn_trig(x, PB + 1, 1'b0);
        cx = turn_trig(x, PB + 1, 1'b1);
        sy = turn_trig(y, PB + 1, 1'b0);
        cy = turn_trig(y, PB + 1, 1'b1);
        ct = turn_trig(phase_reg, PHASE_BITS, 1'b1);
        wu = round_away(ct * sx, 15);
        wu = round_away(wu * sx, 15);
        wu = round_away(wu * cy, 15);
        wu = round_away(wu * sy, 15);
        wv = round_away(ct * sy, 15);
        wv = round_away(wv * sy, 15);
        wv = round_away(wv * cx, 15);
        wv = round_away(wv * sx, 15);
        du = round_away(longint'(dt_reg) * wu, 30 - PB);
        dv = round_away(longint'(dt_reg) * wv, 30 - PB);
        r.nx = PB'(clamp_pos(longint'(x) - du));
        r.ny = PB'(clamp_pos(longint'(y) + dv));
        return r;
    endfunction

    // Send one position; predict it at the accepting edge, then maybe idle.
    task automatic send_position(logic [PB-1:0] x, logic [PB-1:0] y);
        i_valid      <= 1'b1;
        i_x_position <= x;
        i_y_position <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_positions.push_back(advect_step(x, y));
        sent_count++;
        if (!no_gaps && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold the input low and wait until every outstanding transaction is back.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TIME_PHASE) begin
            phase_reg = data[PHASE_BITS-1:0];
        end else begin
            dt_reg = data[STEP_BITS-1:0];
        end
        cfg_count++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_flow(logic [CFG_DATA_BITS-1:0] ph, logic [CFG_DATA_BITS-1:0] dt);
        drain_pipeline();
        write_cfg(CFG_TIME_PHASE, ph);
        write_cfg(CFG_STEP_SIZE, dt);
    endtask

    // Extremes and cardinal points with the reset registers.
    task automatic test_reset_flow();
        send_position(16'h0000, 16'h0000);
        send_position(16'hFFFF, 16'hFFFF);
        send_position(16'h0000, 16'hFFFF);
        send_position(16'hFFFF, 16'h0000);
        send_position(16'h4000, 16'h4000);
        send_position(16'h8000, 16'h8000);
        send_position(16'hC000, 16'h2000);
        send_position(16'h2000, 16'hC000);
    endtask

    // Large steps push particles out of the square: check both clamps.
    task automatic test_saturation();
        set_flow(17'd0, 17'h0FFFF);
        send_position(16'h0100, 16'hA000);
        send_position(16'hFF00, 16'h6000);
        send_position(16'h6000, 16'h0100);
        send_position(16'hA000, 16'hFF00);
        send_position(16'h5555, 16'hAAAA);
        // Reversed flow at t/T = 1, and a step write with its top bit set.
        set_flow(17'h10000, 17'h1FFFF);
        send_position(16'h6000, 16'h0100);
        send_position(16'hA000, 16'hFF00);
        send_position(16'h0100, 16'hA000);
    endtask

    // Quarter phase zeroes the field; phase past one keeps the cosine periodic.
    task automatic test_phase_edges();
        set_flow(17'h08000, 17'd4000);
        send_position(16'h3000, 16'h7000);
        send_position(16'hFFFF, 16'h0001);
        set_flow(17'h1FFFF, 17'd0);
        send_position(16'h1234, 16'hFEDC);
        set_flow(17'h18000, 17'd20000);
        send_position(16'h4000, 16'hC000);
        send_position(16'h7FFF, 16'h8001);
    endtask

    // Random positions over several random flows.
    task automatic test_random_flow();
        logic [CFG_DATA_BITS-1:0] ph, dt;
        for (int phase_no = 0; phase_no < 8; phase_no++) begin
            ph = CFG_DATA_BITS'($urandom_range(0, 131071));
            dt = ($urandom_range(3) == 0) ? 17'($urandom_range(0, 131071))
                                          : 17'($urandom_range(0, 4000));
            set_flow(ph, dt);
            no_gaps = (phase_no == 3);
            for (int n = 0; n < 50; n++) begin
                send_position(PB'($urandom), PB'($urandom));
            end
            no_gaps = 1'b0;
        end
    endtask

    // Result side: compare each accepted transaction, then pick the next stall.
    always @(posedge i_clk) begin
        t_pos exp_pos;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_positions.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h", $time,
                         o_new_x_position, o_new_y_position);
                error_count++;
            end else begin
                exp_pos = expected_positions.pop_front();
                if (o_new_x_position !== exp_pos.nx) begin
                    $display("%0t: new_x mismatch expected %h actual %h", $time,
                             exp_pos.nx, o_new_x_position);
                    error_count++;
                end
                if (o_new_y_position !== exp_pos.ny) begin
                    $display("%0t: new_y mismatch expected %h actual %h", $time,
                             exp_pos.ny, o_new_y_position);
                    error_count++;
                end
            end
        end
        i_stall <= !no_gaps && ($urandom_range(99) < 33);
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_x_position = '0;
        i_y_position = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_TIME_PHASE;
        i_cfg_data   = '0;
        phase_reg    = TIME_PHASE_RST;
        dt_reg       = STEP_SIZE_RST;
        error_count  = 0;
        sent_count   = 0;
        result_count = 0;
        cfg_count    = 0;
        no_gaps      = 1'b0;
        stuck_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_flow();
        test_saturation();
        test_phase_edges();
        test_random_flow();
        drain_pipeline();

        $display("Covered %0d positions, %0d results, %0d register writes", sent_count,
                 result_count, cfg_count);
        $display("Flows: reset, zero and reversed field, clamping, random phases/steps");
        if (error_count == 0 && expected_positions.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[vortex_flow_particle_advect.f]
+incdir+design
design/vfpa_pkg.sv
design/vfpa_sine_rom.sv
design/vortex_flow_particle_advect.sv
design/vfpa_checker.sv
dv/tb_top.sv
